// ===== sv/three_term_recurrence_checksum_core_defines.svh =====
// assertion helpers for the checksum core
`ifndef THREE_TERM_RECURRENCE_CHECKSUM_CORE_DEFINES_SVH
`define THREE_TERM_RECURRENCE_CHECKSUM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TTRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttrc assertion failed");
// next-cycle implication
`define TTRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttrc assertion failed");
`else
`define TTRC_ASSERT_NOW(label, ante, cons)
`define TTRC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/ttrc_pkg.sv =====
package ttrc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  localparam logic [15:0] FIRST_OFFSET = 16'd7;
  localparam logic [7:0]  ALPHA_MUL    = 8'd17;
  localparam logic [7:0]  BETA_MUL     = 8'd31;
  localparam logic [16:0] TERM_MOD     = 17'd65535;
  // 256 * 65535 + 1: keeps a - b positive and adds the 2^64 wrap residue
  localparam logic [25:0] WRAP_BIAS    = 26'd16776961;

endpackage

// ===== sv/ttrc_in_reg.sv =====
module ttrc_in_reg import ttrc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  fire,
  output logic  s1_valid,
  output item_t s1_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  assign in_stall = valid_r && !fire;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== sv/ttrc_recur.sv =====
module ttrc_recur import ttrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  item_t       item,
  output logic [15:0] term
);

  logic [7:0]  idx_r, idx_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic [15:0] prev_r, prev_nxt;
  logic [15:0] curr_r, curr_nxt;

  logic [7:0]  alpha;
  logic [7:0]  beta;
  logic [8:0]  opnd;
  logic [24:0] prod_a;
  logic [23:0] prod_b;
  logic [25:0] diff;
  logic [15:0] step_term;

  // fold 2^16 onto 1, then one conditional subtract
  function automatic logic [15:0] mod_term(input logic [25:0] x);
    logic [16:0] s;
    s = 17'(x[15:0]) + 17'(x[25:16]);
    if (s >= TERM_MOD) begin
      s = s - TERM_MOD;
    end
    return s[15:0];
  endfunction

  assign alpha  = idx_r * ALPHA_MUL;
  assign beta   = idx_r * BETA_MUL;
  assign opnd   = {1'b0, item.data_byte} + {1'b0, alpha};
  assign prod_a = 25'(opnd) * 25'(curr_r);
  assign prod_b = 24'(beta) * 24'(prev_r);

  always_comb begin
    if (prod_a >= 25'(prod_b)) begin
      diff = 26'(prod_a) - 26'(prod_b);
    end else begin
      diff = 26'(prod_a) + WRAP_BIAS - 26'(prod_b);
    end
  end

  assign step_term = mod_term(diff);

  always_comb begin
    idx_nxt    = idx_r;
    in_msg_nxt = in_msg_r;
    prev_nxt   = prev_r;
    curr_nxt   = curr_r;
    if (fire) begin
      if (!in_msg_r) begin
        prev_nxt   = 16'd1;
        curr_nxt   = 16'(item.data_byte) + FIRST_OFFSET;
        idx_nxt    = 8'd1;
        in_msg_nxt = 1'b1;
      end else begin
        prev_nxt = curr_r;
        curr_nxt = step_term;
        idx_nxt  = idx_r + 8'd1;
      end
      if (item.last_byte) begin
        in_msg_nxt = 1'b0;
        idx_nxt    = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= 8'd0;
      in_msg_r <= 1'b0;
      prev_r   <= 16'd1;
      curr_r   <= 16'd1;
    end else begin
      idx_r    <= idx_nxt;
      in_msg_r <= in_msg_nxt;
      prev_r   <= prev_nxt;
      curr_r   <= curr_nxt;
    end
  end

  assign term = curr_nxt;

endmodule

// ===== sv/ttrc_out_reg.sv =====
module ttrc_out_reg import ttrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [15:0] term,
  output logic        slot_free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_checksum
);

  logic        valid_r, valid_nxt;
  logic [15:0] sum_r;

  assign slot_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r <= term;
    end
  end

  assign out_valid    = valid_r;
  assign out_checksum = sum_r;

endmodule

// ===== sv/three_term_recurrence_checksum_core.sv =====
// Three-term recurrence checksum over byte messages, one byte per request with a
// last-byte flag; each last byte yields one 16-bit checksum in 0..65534. The core
// takes one byte every cycle while no final byte waits: a request enters an
// input register; when it fires, both recurrence products, the mod-65535
// reduction and the term update run through one pass of logic into the result
// register, so a checksum is loaded there as its last byte fires. The recurrence
// loop through the current and previous term registers sets the rate. A
// non-final byte never waits on the result side; a final byte waits only while an
// earlier checksum is still held by a stalled output.
`include "three_term_recurrence_checksum_core_defines.svh"

module three_term_recurrence_checksum_core import ttrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_checksum
);

  item_t       in_item;
  item_t       s1_item;
  logic        s1_valid;
  logic        fire;
  logic        slot_free;
  logic [15:0] term;

  assign in_item.data_byte = in_data_byte;
  assign in_item.last_byte = in_last_byte;

  // only a final byte needs room in the result register
  assign fire = s1_valid && (!s1_item.last_byte || slot_free);

  ttrc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .fire     (fire),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  ttrc_recur u_recur (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item),
    .term  (term)
  );

  ttrc_out_reg u_out_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (fire && s1_item.last_byte),
    .term         (term),
    .slot_free    (slot_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_checksum (out_checksum)
  );

  `TTRC_ASSERT_NOW(a_sum_range, out_valid, out_checksum != 16'hFFFF)
  `TTRC_ASSERT_NEXT(a_last_gives_result, fire && s1_item.last_byte, out_valid)
  `TTRC_ASSERT_NOW(a_no_overwrite, fire && s1_item.last_byte && out_valid, !out_stall)
  `TTRC_ASSERT_NOW(a_stall_means_held, in_stall, s1_valid && !fire)

endmodule
